### hw/rtl/ktc_pkg.sv
package ktc_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 63;
    localparam int LINE_BITS_DEF     = 24;

    localparam int HEAD_LEN   = 7;
    localparam int HEAD_W     = 8 * HEAD_LEN;
    localparam int CLASS_W    = 5;
    localparam int LEN_OUT_W  = 6;
    localparam int LINE_OUT_W = 24;
    localparam int S_DATA_W   = 8;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_OPS    = 13;
    localparam int NUM_KW     = 9;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;

    localparam logic [CLASS_W-1:0] CLS_ERROR    = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_OP_FIRST = 5'd1;
    localparam logic [CLASS_W-1:0] CLS_RANGE    = 5'd14;
    localparam logic [CLASS_W-1:0] CLS_OF       = 5'd15;
    localparam logic [CLASS_W-1:0] CLS_INT      = 5'd16;
    localparam logic [CLASS_W-1:0] CLS_REAL     = 5'd17;
    localparam logic [CLASS_W-1:0] CLS_OR       = 5'd18;
    localparam logic [CLASS_W-1:0] CLS_AND      = 5'd19;
    localparam logic [CLASS_W-1:0] CLS_KW_FIRST = 5'd20;
    localparam logic [CLASS_W-1:0] CLS_IDENT    = 5'd29;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] op_char(input int idx);
        logic [7:0] c;
        unique case (idx)
            0:  c = 8'h3D;
            1:  c = 8'h2B;
            2:  c = 8'h2D;
            3:  c = 8'h2A;
            4:  c = 8'h2F;
            5:  c = 8'h7B;
            6:  c = 8'h7D;
            7:  c = 8'h5B;
            8:  c = 8'h5D;
            9:  c = 8'h28;
            10: c = 8'h29;
            11: c = 8'h3B;
            default: c = 8'h3A;
        endcase
        return c;
    endfunction

    // keyword bytes, first char in the low byte, zero padded
    function automatic logic [HEAD_W-1:0] kw_text(input int idx);
        logic [HEAD_W-1:0] t;
        unique case (idx)
            0: t = 56'h65_7261_6c63_6564;
            1: t = 56'h72_6567_6574_6e69;
            2: t = 56'h6e_6165_6c6f_6f62;
            3: t = 56'h00_0000_657a_6973;
            4: t = 56'h00_0000_6c61_6572;
            5: t = 56'h00_0000_7473_696c;
            6: t = 56'h00_0079_6172_7261;
            7: t = 56'h00_6465_6767_616a;
            default: t = 56'h00_7365_756c_6176;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input int idx);
        logic [2:0] n;
        unique case (idx)
            0, 1, 2: n = 3'd7;
            3, 4, 5: n = 3'd4;
            6:       n = 3'd5;
            default: n = 3'd6;
        endcase
        return n;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

### hw/rtl/keyword_token_classifier.sv
// Splits a byte stream into tokens at space and newline and classifies each one.
// One input item per cycle is taken; s_axis_tready falls only when the
// four-entry token queue between the scanner and the classifier is full.
// Every closing item (space, newline or end_of_text) yields one result, which
// passes through the token queue and is then held in an output register; a full
// queue plus a stalled output register is what stops the input.
module keyword_token_classifier #(
    parameter int MAX_TOKEN_LEN = ktc_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LINE_BITS     = ktc_pkg::LINE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ktc_pkg::S_DATA_W-1:0] s_axis_tdata,   // [7:0] text_byte
    input  logic [ktc_pkg::S_USER_W-1:0] s_axis_tuser,   // [0] end_of_text
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [4:0] token_class, [10:5] token_length, [34:11] line_number, [39:35] zero
    output logic [ktc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int REC_W = ktc_pkg::HEAD_W + CNT_W + 2 + LINE_BITS;

    ktc_pkg::q_status_t q_status;
    logic               push_valid;
    logic [REC_W-1:0]   push_data;
    logic               pop;
    logic [REC_W-1:0]   rec_data;

    ktc_scan #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .LINE_BITS    (LINE_BITS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .q_status     (q_status),
        .push_valid   (push_valid),
        .push_data    (push_data)
    );

    ktc_fifo #(
        .WIDTH(REC_W),
        .DEPTH(ktc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push_valid),
        .wr_data(push_data),
        .pop    (pop),
        .rd_data(rec_data),
        .status (q_status)
    );

    ktc_class #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .LINE_BITS    (LINE_BITS)
    ) u_class (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .rec_data     (rec_data),
        .pop          (pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

### hw/rtl/ktc_scan.sv
module ktc_scan #(
    parameter int MAX_TOKEN_LEN = ktc_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LINE_BITS     = ktc_pkg::LINE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ktc_pkg::S_DATA_W-1:0]          s_axis_tdata,
    input  logic [ktc_pkg::S_USER_W-1:0]          s_axis_tuser,
    input  ktc_pkg::q_status_t                    q_status,
    output logic                                  push_valid,
    output logic [ktc_pkg::HEAD_W+$clog2(MAX_TOKEN_LEN+1)+2+LINE_BITS-1:0] push_data
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

    logic [ktc_pkg::HEAD_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       dot_reg, dot_next;
    logic                       bad_reg, bad_next;
    logic [LINE_BITS-1:0]       line_reg, line_next;

    logic       accept;
    logic       eot;
    logic [7:0] c;
    logic       close_tok;

    assign c             = s_axis_tdata[7:0];
    assign eot           = s_axis_tuser[0];
    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign close_tok     = eot || (c == ktc_pkg::CH_SPACE) || (c == ktc_pkg::CH_NEWLINE);

    assign push_valid = accept && close_tok;
    assign push_data  = {line_reg, bad_reg, dot_reg, cnt_reg, head_reg};

    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        dot_next  = dot_reg;
        bad_next  = bad_reg;
        line_next = line_reg;
        if (accept) begin
            if (close_tok) begin
                head_next = '0;
                cnt_next  = '0;
                dot_next  = 1'b0;
                bad_next  = 1'b0;
                if (!eot && (c == ktc_pkg::CH_NEWLINE) && (line_reg != {LINE_BITS{1'b1}})) begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end else begin
                if (cnt_reg < CNT_W'(ktc_pkg::HEAD_LEN)) begin
                    head_next[8*cnt_reg[2:0] +: 8] = c;
                end
                if (cnt_reg < CNT_W'(MAX_TOKEN_LEN)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (c == ktc_pkg::CH_DOT) begin
                    if (dot_reg) begin
                        bad_next = 1'b1;
                    end
                    dot_next = 1'b1;
                end else if (!ktc_pkg::is_digit(c)) begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
            dot_reg  <= 1'b0;
            bad_reg  <= 1'b0;
            line_reg <= LINE_BITS'(1);
        end else begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            dot_reg  <= dot_next;
            bad_reg  <= bad_next;
            line_reg <= line_next;
        end
    end

endmodule

### hw/rtl/ktc_fifo.sv
module ktc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ktc_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [WIDTH-1:0]   wr_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   rd_data,
    output ktc_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hw/rtl/ktc_class.sv
module ktc_class #(
    parameter int MAX_TOKEN_LEN = ktc_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LINE_BITS     = ktc_pkg::LINE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ktc_pkg::q_status_t           q_status,
    input  logic [ktc_pkg::HEAD_W+$clog2(MAX_TOKEN_LEN+1)+2+LINE_BITS-1:0] rec_data,
    output logic                         pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ktc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int PAD_W = ktc_pkg::M_DATA_W - ktc_pkg::CLASS_W - ktc_pkg::LEN_OUT_W
                           - ktc_pkg::LINE_OUT_W;

    logic [ktc_pkg::HEAD_W-1:0] head;
    logic [CNT_W-1:0]           n;
    logic                       dot_seen;
    logic                       num_bad;
    logic [LINE_BITS-1:0]       line;
    logic [7:0]                 b0, b1, b2;
    logic                       op_hit;
    logic [ktc_pkg::CLASS_W-1:0] op_cls;
    logic                       kw_hit;
    logic [ktc_pkg::CLASS_W-1:0] kw_cls;
    logic [ktc_pkg::CLASS_W-1:0] cls;

    logic                          valid_reg, valid_next;
    logic [ktc_pkg::CLASS_W-1:0]   cls_reg;
    logic [ktc_pkg::LEN_OUT_W-1:0] len_reg;
    logic [ktc_pkg::LINE_OUT_W-1:0] line_out_reg;

    assign {line, num_bad, dot_seen, n, head} = rec_data;
    assign b0 = head[7:0];
    assign b1 = head[15:8];
    assign b2 = head[23:16];

    always_comb begin
        op_hit = 1'b0;
        op_cls = ktc_pkg::CLS_ERROR;
        for (int i = 0; i < ktc_pkg::NUM_OPS; i++) begin
            if (b0 == ktc_pkg::op_char(i)) begin
                op_hit = 1'b1;
                op_cls = ktc_pkg::CLS_OP_FIRST + ktc_pkg::CLASS_W'(i);
            end
        end
    end

    always_comb begin
        kw_hit = 1'b0;
        kw_cls = ktc_pkg::CLS_ERROR;
        for (int i = 0; i < ktc_pkg::NUM_KW; i++) begin
            if ((n == CNT_W'(ktc_pkg::kw_len(i))) && (head == ktc_pkg::kw_text(i))) begin
                kw_hit = 1'b1;
                kw_cls = ktc_pkg::CLS_KW_FIRST + ktc_pkg::CLASS_W'(i);
            end
        end
    end

    always_comb begin
        priority if (n == '0) begin
            cls = ktc_pkg::CLS_ERROR;
        end else if ((n == CNT_W'(1)) && op_hit) begin
            cls = op_cls;
        end else if ((n == CNT_W'(2)) && (b0 == ktc_pkg::CH_DOT) && (b1 == ktc_pkg::CH_DOT)) begin
            cls = ktc_pkg::CLS_RANGE;
        end else if ((n == CNT_W'(2)) && (b0 == ktc_pkg::CH_O) && (b1 == ktc_pkg::CH_F)) begin
            cls = ktc_pkg::CLS_OF;
        end else if (ktc_pkg::is_digit(b0)) begin
            cls = num_bad ? ktc_pkg::CLS_ERROR
                          : (dot_seen ? ktc_pkg::CLS_REAL : ktc_pkg::CLS_INT);
        end else if ((n == CNT_W'(3)) && (b0 == ktc_pkg::CH_BAR) && (b1 == ktc_pkg::CH_BAR)
                     && (b2 == ktc_pkg::CH_BAR)) begin
            cls = ktc_pkg::CLS_OR;
        end else if ((n == CNT_W'(3)) && (b0 == ktc_pkg::CH_AMP) && (b1 == ktc_pkg::CH_AMP)
                     && (b2 == ktc_pkg::CH_AMP)) begin
            cls = ktc_pkg::CLS_AND;
        end else if (kw_hit) begin
            cls = kw_cls;
        end else if (((b0 >= ktc_pkg::CH_LOW_A) && (b0 <= ktc_pkg::CH_LOW_Z))
                     || ((b0 >= ktc_pkg::CH_UP_A) && (b0 <= ktc_pkg::CH_UP_Z))) begin
            cls = ktc_pkg::CLS_IDENT;
        end else begin
            cls = ktc_pkg::CLS_ERROR;
        end
    end

    assign pop = !q_status.empty && (!valid_reg || m_axis_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cls_reg      <= cls;
            len_reg      <= ktc_pkg::LEN_OUT_W'(n);
            line_out_reg <= ktc_pkg::LINE_OUT_W'(line);
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, line_out_reg, len_reg, cls_reg};

endmodule

### hw/rtl/ktc_checker.sv
module ktc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [ktc_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic [ktc_pkg::S_USER_W-1:0] s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [ktc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= ktc_pkg::CLS_IDENT)
        else $error("token class out of range");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
        else $error("tdata padding not zero");

    a_empty_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[10:5] == 6'd0) |-> m_axis_tdata[4:0] == ktc_pkg::CLS_ERROR)
        else $error("empty token with non-error class");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[34:11] != 24'd0)
        else $error("line number zero");

endmodule

bind keyword_token_classifier ktc_checker u_ktc_checker (.*);
